// ===== sv/q12mm_pkg.sv =====
// ----------------------------------------------------------------------------
// q12mm_pkg: shared types and constants of the Q12 3x3 matrix multiplier
// Matrix geometry, accumulator width, sequencer states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package q12mm_pkg;

   localparam int MATRIX_DIM            = 3;
   localparam int MATRIX_CELLS          = 9;
   localparam int INDEX_WIDTH           = 4;
   localparam int COORD_WIDTH           = 2;
   localparam int ACC_WIDTH             = 32;
   localparam int DEFAULT_ELEMENT_WIDTH = 16;
   localparam int DEFAULT_FRACTION_BITS = 12;

   localparam logic [COORD_WIDTH-1:0] LAST_COORD = COORD_WIDTH'(MATRIX_DIM - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   store_write;
      logic                   read_enable;
      logic                   read_first;
      logic                   read_last;
      logic [COORD_WIDTH-1:0] row;
      logic [COORD_WIDTH-1:0] col;
      logic [COORD_WIDTH-1:0] term;
   } cmd_type;

   typedef struct packed {
      logic sum_ready;
   } status_type;

endpackage

// ===== sv/q12mm_req_if.sv =====
// ----------------------------------------------------------------------------
// q12mm_req_if: request channel of the Q12 3x3 matrix multiplier
// One element pair per request, plus the flag that starts a run.
// ----------------------------------------------------------------------------
interface q12mm_req_if
   import q12mm_pkg::*;
#(
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
);
   logic                            valid;
   logic                            ready;
   logic [INDEX_WIDTH-1:0]          element_index;
   logic signed [ELEMENT_WIDTH-1:0] left_value;
   logic signed [ELEMENT_WIDTH-1:0] right_value;
   logic                            start_multiply;

   modport source (
      output valid, element_index, left_value, right_value, start_multiply,
      input  ready
   );

   modport sink (
      input  valid, element_index, left_value, right_value, start_multiply,
      output ready
   );
endinterface

// ===== sv/q12mm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// q12mm_rsp_if: result channel of the Q12 3x3 matrix multiplier
// One product element per transfer, row-major, last one flagged.
// ----------------------------------------------------------------------------
interface q12mm_rsp_if
   import q12mm_pkg::*;
#(
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH
);
   logic                            valid;
   logic                            ready;
   logic [COORD_WIDTH-1:0]          result_row;
   logic [COORD_WIDTH-1:0]          result_column;
   logic signed [ELEMENT_WIDTH-1:0] result_value;
   logic                            final_element;

   modport source (
      output valid, result_row, result_column, result_value, final_element,
      input  ready
   );

   modport sink (
      input  valid, result_row, result_column, result_value, final_element,
      output ready
   );
endinterface

// ===== sv/q12mm_datapath.sv =====
// ----------------------------------------------------------------------------
// q12mm_datapath: operand stores and multiply-accumulate pipeline
// Two 9-entry stores, registered reads, one shared multiplier and a
// 32-bit wrapping accumulator with the Q12 rescale on its output.
// ----------------------------------------------------------------------------
module q12mm_datapath
   import q12mm_pkg::*;
#(
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         cmd,
   input  logic [INDEX_WIDTH-1:0]          element_index,
   input  logic signed [ELEMENT_WIDTH-1:0] left_value,
   input  logic signed [ELEMENT_WIDTH-1:0] right_value,
   output status_type                      status,
   output logic signed [ELEMENT_WIDTH-1:0] result_value
);

   logic signed [ELEMENT_WIDTH-1:0] left_store  [MATRIX_CELLS];
   logic signed [ELEMENT_WIDTH-1:0] right_store [MATRIX_CELLS];

   logic [INDEX_WIDTH-1:0] left_addr;
   logic [INDEX_WIDTH-1:0] right_addr;

   logic signed [ELEMENT_WIDTH-1:0] left_rd_ff;
   logic signed [ELEMENT_WIDTH-1:0] right_rd_ff;
   logic                            rd_valid_ff;
   logic                            rd_first_ff;
   logic                            rd_last_ff;

   logic signed [ACC_WIDTH-1:0] left_wide;
   logic signed [ACC_WIDTH-1:0] right_wide;
   logic signed [ACC_WIDTH-1:0] prod_in;
   logic signed [ACC_WIDTH-1:0] prod_ff;
   logic                        mul_valid_ff;
   logic                        mul_first_ff;
   logic                        mul_last_ff;

   logic signed [ACC_WIDTH-1:0] acc_in;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic                        done_ff;
   logic signed [ACC_WIDTH-1:0] acc_scaled;

   // row-major: left walks along a row, right down a column
   assign left_addr  = INDEX_WIDTH'(cmd.row) * INDEX_WIDTH'(MATRIX_DIM)
                       + INDEX_WIDTH'(cmd.term);
   assign right_addr = INDEX_WIDTH'(cmd.term) * INDEX_WIDTH'(MATRIX_DIM)
                       + INDEX_WIDTH'(cmd.col);

   always_ff @(posedge clock) begin
      if (cmd.store_write && (element_index < INDEX_WIDTH'(MATRIX_CELLS))) begin
         left_store[element_index]  <= left_value;
         right_store[element_index] <= right_value;
      end
      if (cmd.read_enable) begin
         left_rd_ff  <= left_store[left_addr];
         right_rd_ff <= right_store[right_addr];
         rd_first_ff <= cmd.read_first;
         rd_last_ff  <= cmd.read_last;
      end
   end

   // low 32 bits of the product of sign-extended operands
   assign left_wide  = ACC_WIDTH'(left_rd_ff);
   assign right_wide = ACC_WIDTH'(right_rd_ff);
   assign prod_in    = left_wide * right_wide;

   assign acc_in = mul_first_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prod_ff      <= prod_in;
         mul_first_ff <= rd_first_ff;
         mul_last_ff  <= rd_last_ff;
      end
      if (mul_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.read_enable;
         mul_valid_ff <= rd_valid_ff;
         done_ff      <= mul_valid_ff && mul_last_ff;
      end
   end

   assign acc_scaled       = acc_ff >>> FRACTION_BITS;
   assign result_value     = acc_scaled[ELEMENT_WIDTH-1:0];
   assign status.sum_ready = done_ff;

endmodule

// ===== sv/q12mm_controller.sv =====
// ----------------------------------------------------------------------------
// q12mm_controller: run sequencer of the Q12 3x3 matrix multiplier
// Takes element pairs while idle, then walks the nine product cells, issuing
// three reads per cell and holding each result until it is taken.
// ----------------------------------------------------------------------------
module q12mm_controller
   import q12mm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_start,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_WIDTH-1:0] rsp_row,
   output logic [COORD_WIDTH-1:0] rsp_col,
   output logic                   rsp_final,
   output cmd_type                cmd,
   input  status_type             status
);

   state_type              state_ff, state_in;
   logic [COORD_WIDTH-1:0] row_ff, row_in;
   logic [COORD_WIDTH-1:0] col_ff, col_in;
   logic [COORD_WIDTH-1:0] term_ff, term_in;
   logic                   last_cell;

   assign last_cell = (row_ff == LAST_COORD) && (col_ff == LAST_COORD);

   // next state
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_start) begin
               state_in = ST_ISSUE;
               row_in   = '0;
               col_in   = '0;
               term_in  = '0;
            end
         end
         ST_ISSUE: begin
            if (term_ff == LAST_COORD) begin
               state_in = ST_DRAIN;
               term_in  = '0;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.sum_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (last_cell) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (col_ff == LAST_COORD) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      cmd.store_write = 1'b0;
      cmd.read_enable = 1'b0;
      cmd.read_first  = (term_ff == '0);
      cmd.read_last   = (term_ff == LAST_COORD);
      cmd.row         = row_ff;
      cmd.col         = col_ff;
      cmd.term        = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.store_write = req_valid;
         end
         ST_ISSUE: cmd.read_enable = 1'b1;
         ST_DRAIN: ;
         ST_EMIT:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign rsp_row   = row_ff;
   assign rsp_col   = col_ff;
   assign rsp_final = last_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         term_ff  <= term_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_sum_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.sum_ready |-> (state_ff == ST_DRAIN))
      else $error("accumulated sum arrived outside the drain wait");

   a_coord_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(row_ff) && $stable(col_ff) && rsp_valid))
      else $error("result coordinates moved while stalled");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final) |=> (state_ff == ST_IDLE))
      else $error("run did not end after the ninth result");
`endif

endmodule

// ===== sv/q12_matrix3x3_multiply_top.sv =====
// ----------------------------------------------------------------------------
// q12_matrix3x3_multiply_top: Q12 fixed-point 3x3 matrix multiplier
// Loads element pairs of two 3x3 matrices and, on a start request, emits the
// nine elements of their product in row-major order.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          payload
//   --------  ---  -----------------  -----------------------------------------
//   req_bus   in   valid / ready      element_index, left_value, right_value,
//                                     start_multiply
//   rsp_bus   out  valid / ready      result_row, result_column, result_value,
//                                     final_element
//
// Operation: a request is taken while the block is idle. After a start
//   request each product element is built from three store reads, which then
//   pass the read, multiply and accumulate registers before the output
//   state; elements are built one at a time through the single shared
//   multiplier and its pipeline, and rsp stalls lengthen a run.
// Reset: synchronous, active high; clears the sequencer, not the stores.
// Stalls: a result holds on rsp_bus until taken; no request is taken mid-run.
// ----------------------------------------------------------------------------
module q12_matrix3x3_multiply_top
   import q12mm_pkg::*;
#(
   parameter int ELEMENT_WIDTH = DEFAULT_ELEMENT_WIDTH,
   parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
   input logic        clock,
   input logic        reset,
   q12mm_req_if.sink   req_bus,
   q12mm_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // sequencer: request acceptance, cell walk, result handshake
   q12mm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_start (req_bus.start_multiply),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_row   (rsp_bus.result_row),
      .rsp_col   (rsp_bus.result_column),
      .rsp_final (rsp_bus.final_element),
      .cmd       (cmd),
      .status    (status)
   );

   // stores and multiply-accumulate; result held in the accumulator register
   q12mm_datapath #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .element_index (req_bus.element_index),
      .left_value    (req_bus.left_value),
      .right_value   (req_bus.right_value),
      .status        (status),
      .result_value  (rsp_bus.result_value)
   );

endmodule
